[sv/kdv_pkg.sv]
package kdv_pkg;

	localparam int SINE_TABLE_DEPTH = 256;
	localparam int PHASE_BITS = 24;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam int INC_W = 23;
	localparam int ENV_W = 24;
	localparam int SINE_W = 16;
	localparam int SAMPLE_W = 24;

	typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [INC_W-1:0] inc_t;
	typedef logic [ENV_W-1:0] env_t;
	typedef logic [SINE_W-1:0] sine_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;

	localparam cfg_addr_t REG_START_INC = 3'd0;
	localparam cfg_addr_t REG_END_INC = 3'd1;
	localparam cfg_addr_t REG_PITCH_DECAY = 3'd2;
	localparam cfg_addr_t REG_AMP_DECAY = 3'd3;
	localparam cfg_addr_t REG_CLICK_LEVEL = 3'd4;
	localparam cfg_addr_t REG_GAIN = 3'd5;
	localparam cfg_addr_t REG_LOOP_ENABLE = 3'd6;
	localparam cfg_addr_t REG_BEAT_FRAMES = 3'd7;

	localparam env_t ENV_ONE = 24'hFFFFFF;
	localparam env_t AMP_FLOOR = 24'd839;
	localparam longint Q30_HALF_PI = 64'sd1686629713;

endpackage

[sv/kdv_in_if.sv]
interface kdv_in_if;
	logic valid;
	logic ready;
	logic manual_trigger;

	modport source (output valid, output manual_trigger, input ready);
	modport sink (input valid, input manual_trigger, output ready);
endinterface

[sv/kdv_out_if.sv]
interface kdv_out_if;
	logic valid;
	logic ready;
	kdv_pkg::sample_t sample_out;
	logic voice_active;

	modport source (output valid, output sample_out, output voice_active, input ready);
	modport sink (input valid, input sample_out, input voice_active, output ready);
endinterface

[sv/kdv_sine_rom.sv]
module kdv_sine_rom #(
	parameter int DEPTH = kdv_pkg::SINE_TABLE_DEPTH,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic [AW-1:0]         addr,
	output kdv_pkg::sine_t        data
);
	import kdv_pkg::*;

	typedef sine_t rom_t [DEPTH];

	function automatic rom_t build_rom();
		rom_t r;
		longint x, x2, term, sum;
		for (int i = 0; i < DEPTH; i++) begin
			x = (Q30_HALF_PI * longint'(2 * i + 1)) / (2 * DEPTH);
			x2 = (x * x) >>> 30;
			term = x;
			sum = x;
			term = ((term * x2) >>> 30) / 6;   sum = sum - term;
			term = ((term * x2) >>> 30) / 20;  sum = sum + term;
			term = ((term * x2) >>> 30) / 42;  sum = sum - term;
			term = ((term * x2) >>> 30) / 72;  sum = sum + term;
			term = ((term * x2) >>> 30) / 110; sum = sum - term;
			term = ((term * x2) >>> 30) / 156; sum = sum + term;
			term = ((term * x2) >>> 30) / 210; sum = sum - term;
			if (sum < 0)
				sum = 0;
			r[i] = SINE_W'((sum * 32767 + (longint'(1) << 29)) >>> 30);
		end
		return r;
	endfunction

	localparam rom_t ROM = build_rom();

	sine_t data_q;

	always_ff @(posedge clk) begin
		data_q <= ROM[addr];
	end

	assign data = data_q;

endmodule

[sv/kick_drum_voice.sv]
// For a sounding voice each input beat steps through the states INC, PHASE, ROM, TONE, MIX,
// GAIN, SAT, AMPW, PITW and FIN before its output beat; a silent voice goes straight to FIN.
// A new input beat is taken only after FIN of the previous one; the last state (FIN)
// waits while the previous output beat is still unaccepted.
// The shared 24x24 multiplier runs five products per sounding sample in sequence.
// Ready is high only while the sequencer is idle.
// arst_n clears envelopes, phase and counters and loads register defaults.
module kick_drum_voice #(
	parameter int SINE_TABLE_DEPTH = kdv_pkg::SINE_TABLE_DEPTH,
	parameter int PHASE_BITS = kdv_pkg::PHASE_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  kdv_pkg::cfg_addr_t cfg_addr,
	input  kdv_pkg::cfg_data_t cfg_wdata,
	kdv_in_if.sink             in_ch,
	kdv_out_if.source          out_ch
);
	import kdv_pkg::*;

	// table depth must be a power of two
	localparam int AW = $clog2(SINE_TABLE_DEPTH);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_INC   = 4'd1;
	localparam logic [3:0] ST_PHASE = 4'd2;
	localparam logic [3:0] ST_ROM   = 4'd3;
	localparam logic [3:0] ST_TONE  = 4'd4;
	localparam logic [3:0] ST_MIX   = 4'd5;
	localparam logic [3:0] ST_GAIN  = 4'd6;
	localparam logic [3:0] ST_SAT   = 4'd7;
	localparam logic [3:0] ST_AMPW  = 4'd8;
	localparam logic [3:0] ST_PITW  = 4'd9;
	localparam logic [3:0] ST_FIN   = 4'd10;

	logic [3:0] state_q;

	inc_t                start_q, end_q;
	env_t                pitch_decay_q, amp_decay_q;
	logic signed [15:0]  click_q;
	logic [15:0]         gain_q;
	logic                loop_q;
	logic [23:0]         beat_q;

	logic [PHASE_BITS-1:0] phase_q;
	env_t                amp_q, pitch_q;
	logic [1:0]          sst_q;
	logic                sounding_q, fired_q;
	logic [23:0]         ftnb_q;

	logic [47:0]         prod_q;
	logic [23:0]         mix_mag_q;
	logic                mix_neg_q;
	sample_t             result_q;

	logic                out_valid_q;
	sample_t             out_sample_q;
	logic                out_active_q;

	logic [23:0]         mul_a, mul_b;
	inc_t                diff, frac, inc;
	logic                up;
	logic [AW-1:0]       rom_addr, idx;
	sine_t               rom_data;
	logic [23:0]         tone_mag;
	logic signed [24:0]  tone_s, click_s, mix_s;
	logic [25:0]         scaled;
	logic                fire;
	logic                out_free;

	kdv_sine_rom #(.DEPTH(SINE_TABLE_DEPTH), .AW(AW)) u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	assign up = (start_q >= end_q);
	assign diff = up ? (start_q - end_q) : (end_q - start_q);
	assign frac = prod_q[46:24];
	assign inc = up ? (end_q + frac) : (end_q - frac);

	assign idx = phase_q[PHASE_BITS-3 -: AW];
	assign rom_addr = phase_q[PHASE_BITS-2] ? ~idx : idx;

	assign tone_mag = prod_q[39:16];
	assign tone_s = phase_q[PHASE_BITS-1] ? -$signed({1'b0, tone_mag}) : $signed({1'b0, tone_mag});
	assign click_s = sst_q[1] ? 25'sd0 : 25'($signed({click_q, 8'd0}));
	assign mix_s = tone_s + click_s;
	assign scaled = prod_q[39:14];

	assign fire = (loop_q ? (ftnb_q == 24'd0) : !fired_q) || in_ch.manual_trigger;
	assign out_free = !out_valid_q || out_ch.ready;

	always_comb begin
		case (state_q)
			ST_INC: begin
				mul_a = 24'(diff);
				mul_b = pitch_q;
			end
			ST_TONE: begin
				mul_a = 24'(rom_data);
				mul_b = amp_q;
			end
			ST_GAIN: begin
				mul_a = mix_mag_q;
				mul_b = 24'(gain_q);
			end
			ST_SAT: begin
				mul_a = amp_q;
				mul_b = amp_decay_q;
			end
			ST_AMPW: begin
				mul_a = pitch_q;
				mul_b = pitch_decay_q;
			end
			default: begin
				mul_a = 24'd0;
				mul_b = 24'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (state_q == ST_MIX) begin
			mix_neg_q <= mix_s[24];
			mix_mag_q <= mix_s[24] ? 24'(-mix_s) : mix_s[23:0];
		end
		if (state_q == ST_SAT) begin
			if (!mix_neg_q && scaled > 26'd8388607)
				result_q <= 24'sh7FFFFF;
			else if (mix_neg_q && scaled > 26'd8388608)
				result_q <= 24'sh800000;
			else if (mix_neg_q)
				result_q <= -$signed(scaled[23:0]);
			else
				result_q <= $signed(scaled[23:0]);
		end
		if (state_q == ST_IDLE)
			result_q <= '0;
		if (state_q == ST_FIN && out_free) begin
			out_sample_q <= result_q;
			out_active_q <= sounding_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 23'd41943;
			end_q <= 23'd17476;
			pitch_decay_q <= 24'd16760000;
			amp_decay_q <= 24'd16774000;
			click_q <= 16'sd0;
			gain_q <= 16'd16384;
			loop_q <= 1'b0;
			beat_q <= 24'd24000;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_START_INC:   start_q <= cfg_wdata[22:0];
				REG_END_INC:     end_q <= cfg_wdata[22:0];
				REG_PITCH_DECAY: pitch_decay_q <= cfg_wdata;
				REG_AMP_DECAY:   amp_decay_q <= cfg_wdata;
				REG_CLICK_LEVEL: click_q <= $signed(cfg_wdata[15:0]);
				REG_GAIN:        gain_q <= cfg_wdata[15:0];
				REG_LOOP_ENABLE: loop_q <= cfg_wdata[0];
				REG_BEAT_FRAMES: beat_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			amp_q <= '0;
			pitch_q <= '0;
			sst_q <= 2'd0;
			sounding_q <= 1'b0;
			fired_q <= 1'b0;
			ftnb_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						if (loop_q) begin
							ftnb_q <= (ftnb_q == 24'd0) ? beat_q : ftnb_q - 24'd1;
						end else if (!fired_q) begin
							fired_q <= 1'b1;
						end
						if (fire) begin
							phase_q <= '0;
							amp_q <= ENV_ONE;
							pitch_q <= ENV_ONE;
							sst_q <= 2'd0;
							sounding_q <= 1'b1;
						end
						state_q <= (fire || sounding_q) ? ST_INC : ST_FIN;
					end
				end
				ST_INC:   state_q <= ST_PHASE;
				ST_PHASE: begin
					phase_q <= phase_q + PHASE_BITS'(inc);
					state_q <= ST_ROM;
				end
				ST_ROM:   state_q <= ST_TONE;
				ST_TONE:  state_q <= ST_MIX;
				ST_MIX:   state_q <= ST_GAIN;
				ST_GAIN:  state_q <= ST_SAT;
				ST_SAT:   state_q <= ST_AMPW;
				ST_AMPW: begin
					amp_q <= prod_q[47:24];
					if (amp_q < AMP_FLOOR)
						sounding_q <= 1'b0;
					state_q <= ST_PITW;
				end
				ST_PITW: begin
					pitch_q <= prod_q[47:24];
					if (!sst_q[1])
						sst_q <= sst_q + 2'd1;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.sample_out = out_sample_q;
	assign out_ch.voice_active = out_active_q;

endmodule
